[hdl/window_statistics_decimator_defines.svh]
// Assertion macros used by the checker of the window statistics decimator.
`ifndef WINDOW_STATISTICS_DECIMATOR_DEFINES_SVH
`define WINDOW_STATISTICS_DECIMATOR_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define WSD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("window statistics check failed");

// Next-cycle implication, idle during reset.
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("window statistics check failed");

`endif

[hdl/wsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  localparam int WLEN_W         = 11;
  localparam int MIN_WINDOW     = 10;
  localparam int MEAN_W         = 32;
  localparam int STD_W          = 32;
  localparam int QUO_W          = 64;
  localparam int FRAC_BITS      = 8;
  localparam int VAR_SCALE_BITS = 16;

  typedef struct packed {
    logic acc_en;
    logic load_mul_a;
    logic load_mul_b;
    logic mul_step;
    logic load_div_mean;
    logic div_step;
    logic load_div_std;
    logic load_sqrt;
    logic sqrt_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic window_done;
  } sts_t;

endpackage

`default_nettype wire

[hdl/wsd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsd_ctrl #(
  parameter int MUL_STEPS  = 34,
  parameter int DIV_STEPS  = 84,
  parameter int SQRT_STEPS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  input  wire wsd_pkg::sts_t sts,
  output wsd_pkg::cmd_t     cmd
);

  localparam int MAX_AB    = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
  localparam int MAX_STEPS = (MAX_AB > SQRT_STEPS) ? MAX_AB : SQRT_STEPS;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  typedef enum logic [7:0] {
    ST_ACCUM    = 8'b0000_0001,
    ST_LOAD     = 8'b0000_0010,
    ST_MUL_A    = 8'b0000_0100,
    ST_MUL_B    = 8'b0000_1000,
    ST_DIV_MEAN = 8'b0001_0000,
    ST_DIV_STD  = 8'b0010_0000,
    ST_SQRT     = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    case (state)
      ST_ACCUM: begin
        cmd.acc_en = in_valid;
        if (in_valid && sts.window_done) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_mul_a = 1'b1;
        state_next     = ST_MUL_A;
        step_next      = '0;
      end
      ST_MUL_A: begin
        if (step == STEP_W'(MUL_STEPS)) begin
          cmd.load_mul_b = 1'b1;
          state_next     = ST_MUL_B;
          step_next      = '0;
        end else begin
          cmd.mul_step = 1'b1;
          step_next    = step + 1'b1;
        end
      end
      ST_MUL_B: begin
        if (step == STEP_W'(MUL_STEPS)) begin
          cmd.load_div_mean = 1'b1;
          state_next        = ST_DIV_MEAN;
          step_next         = '0;
        end else begin
          cmd.mul_step = 1'b1;
          step_next    = step + 1'b1;
        end
      end
      ST_DIV_MEAN: begin
        if (step == STEP_W'(DIV_STEPS)) begin
          cmd.load_div_std = 1'b1;
          state_next       = ST_DIV_STD;
          step_next        = '0;
        end else begin
          cmd.div_step = 1'b1;
          step_next    = step + 1'b1;
        end
      end
      ST_DIV_STD: begin
        if (step == STEP_W'(DIV_STEPS)) begin
          cmd.load_sqrt = 1'b1;
          state_next    = ST_SQRT;
          step_next     = '0;
        end else begin
          cmd.div_step = 1'b1;
          step_next    = step + 1'b1;
        end
      end
      ST_SQRT: begin
        if (step == STEP_W'(SQRT_STEPS)) begin
          state_next = ST_FINISH;
          step_next  = '0;
        end else begin
          cmd.sqrt_step = 1'b1;
          step_next     = step + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
        step_next  = '0;
      end
    endcase
  end

  assign in_stall       = (state != ST_ACCUM);
  assign out_valid_next = cmd.emit | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[hdl/wsd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsd_datapath #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              window_length_we,
  input  wire logic [wsd_pkg::WLEN_W-1:0]        window_length,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample,
  input  wire wsd_pkg::cmd_t                     cmd,
  output wsd_pkg::sts_t                          sts,
  output logic signed [wsd_pkg::MEAN_W-1:0]      window_mean,
  output logic signed [SAMPLE_BITS-1:0]          window_min,
  output logic signed [SAMPLE_BITS-1:0]          window_max,
  output logic [wsd_pkg::STD_W-1:0]              window_std
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int LOG_W  = $clog2(MAX_WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + LOG_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1 + LOG_W;
  localparam int PROD_W = 2 * SUM_W;
  localparam int DIV_W  = PROD_W + wsd_pkg::VAR_SCALE_BITS;
  localparam int D_W    = 2 * CNT_W;
  localparam int QUO_W  = wsd_pkg::QUO_W;
  localparam int ROOT_W = QUO_W / 2;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // accumulators
  logic [wsd_pkg::WLEN_W-1:0]    wlen;
  logic [CNT_W-1:0]              count;
  logic signed [SUM_W-1:0]       sum;
  logic [SQ_W-1:0]               sumsq;
  logic signed [SAMPLE_BITS-1:0] vmin, vmax;

  // serial multiplier
  logic [SQ_W-1:0]   mcand;
  logic [SUM_W-1:0]  mplier;
  logic [PROD_W-1:0] macc, prod_a, var_num;

  // serial divider
  logic [DIV_W-1:0]  dvd;
  logic [D_W-1:0]    divisor, drem;
  logic [QUO_W-1:0]  quo;
  logic [wsd_pkg::MEAN_W-1:0] mean_reg;

  // serial square root
  logic [QUO_W-1:0]  sx;
  logic [ROOT_W:0]   srem;
  logic [ROOT_W-1:0] root;

  logic [CNT_W-1:0]         eff_len, count_inc;
  logic [SAMPLE_BITS-1:0]   s_mag;
  logic [2*SAMPLE_BITS-1:0] s_sq;
  logic [SUM_W-1:0]         sum_mag;
  logic [D_W:0]             d_trial;
  logic                     d_ge;
  logic [QUO_W-1:0]         q_up, mean_calc;
  logic [ROOT_W+2:0]        r_trial_rem, r_trial;
  logic                     r_ge;

  always_comb begin
    if (wlen < wsd_pkg::WLEN_W'(wsd_pkg::MIN_WINDOW)) begin
      eff_len = CNT_W'(wsd_pkg::MIN_WINDOW);
    end else if (int'(wlen) > MAX_WINDOW) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(wlen);
    end
  end

  assign count_inc       = count + 1'b1;
  assign sts.window_done = (count_inc >= eff_len);

  assign s_mag   = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign s_sq    = s_mag * s_mag;
  assign sum_mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

  assign d_trial = {drem, dvd[DIV_W-1]};
  assign d_ge    = (d_trial >= {1'b0, divisor});

  assign q_up      = quo + QUO_W'(drem != '0);
  assign mean_calc = sum[SUM_W-1] ? (QUO_W'(0) - q_up) : quo;

  assign r_trial_rem = {srem, sx[QUO_W-1 -: 2]};
  assign r_trial     = (ROOT_W+3)'({root, 2'b01});
  assign r_ge        = (r_trial_rem >= r_trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= wsd_pkg::WLEN_W'(wsd_pkg::MIN_WINDOW);
    end else if (window_length_we) begin
      wlen <= window_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      count <= '0;
      sum   <= '0;
      sumsq <= '0;
      vmin  <= SAMPLE_MAX;
      vmax  <= SAMPLE_MIN;
    end else if (cmd.acc_en) begin
      count <= count_inc;
      sum   <= sum + SUM_W'(sample);
      sumsq <= sumsq + SQ_W'(s_sq);
      if (sample < vmin) begin
        vmin <= sample;
      end
      if (sample > vmax) begin
        vmax <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mul_a) begin
      mcand  <= sumsq;
      mplier <= SUM_W'(count);
      macc   <= '0;
    end else if (cmd.load_mul_b) begin
      prod_a <= macc;
      mcand  <= SQ_W'(sum_mag);
      mplier <= sum_mag;
      macc   <= '0;
    end else if (cmd.mul_step) begin
      macc   <= {macc[PROD_W-2:0], 1'b0} + (mplier[SUM_W-1] ? PROD_W'(mcand) : '0);
      mplier <= {mplier[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div_mean) begin
      var_num <= (macc > prod_a) ? '0 : (prod_a - macc);
      dvd     <= DIV_W'(sum_mag) << wsd_pkg::FRAC_BITS;
      divisor <= D_W'(count);
      drem    <= '0;
      quo     <= '0;
    end else if (cmd.load_div_std) begin
      mean_reg <= mean_calc[wsd_pkg::MEAN_W-1:0];
      dvd      <= DIV_W'(var_num) << wsd_pkg::VAR_SCALE_BITS;
      divisor  <= D_W'(count) * D_W'(count);
      drem     <= '0;
      quo      <= '0;
    end else if (cmd.div_step) begin
      drem <= d_ge ? D_W'(d_trial - {1'b0, divisor}) : D_W'(d_trial);
      quo  <= {quo[QUO_W-2:0], d_ge};
      dvd  <= {dvd[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sqrt) begin
      sx   <= quo;
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      srem <= r_ge ? (ROOT_W+1)'(r_trial_rem - r_trial) : (ROOT_W+1)'(r_trial_rem);
      root <= {root[ROOT_W-2:0], r_ge};
      sx   <= {sx[QUO_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      window_mean <= mean_reg;
      window_min  <= vmin;
      window_max  <= vmax;
      window_std  <= wsd_pkg::STD_W'(root);
    end
  end

endmodule

`default_nettype wire

[hdl/window_statistics_decimator.sv]
// Channel  | Handshake               | Beat contents
// ---------+-------------------------+--------------------------------------------
// input    | in_valid / in_stall     | sample
// output   | out_valid / out_stall   | window_mean, window_min, window_max, window_std
// config   | window_length_we        | window_length
//
// A sample that does not close a window is taken without in_stall.
// The sample that closes a window is followed by in_stall while one shift-add
// multiplier runs twice, one restoring divider runs twice, then a two-bits-per-cycle
// square root runs and the finished record waits to be emitted.
// Reset (rst, synchronous) clears the accumulators and sets window_length to 10.
// A held record under out_stall keeps the finished next record waiting, not lost.
`timescale 1ns / 1ps
`default_nettype none

module window_statistics_decimator #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          window_length_we,
  input  wire logic [wsd_pkg::WLEN_W-1:0]    window_length,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [wsd_pkg::MEAN_W-1:0]  window_mean,
  output logic signed [SAMPLE_BITS-1:0]      window_min,
  output logic signed [SAMPLE_BITS-1:0]      window_max,
  output logic [wsd_pkg::STD_W-1:0]          window_std
);

  localparam int LOG_W  = $clog2(MAX_WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + LOG_W;
  localparam int DIV_W  = 2 * SUM_W + wsd_pkg::VAR_SCALE_BITS;
  localparam int ROOT_W = wsd_pkg::QUO_W / 2;

  wsd_pkg::cmd_t cmd;
  wsd_pkg::sts_t sts;

  wsd_ctrl #(
    .MUL_STEPS  (SUM_W),
    .DIV_STEPS  (DIV_W),
    .SQRT_STEPS (ROOT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  wsd_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .window_length_we (window_length_we),
    .window_length    (window_length),
    .sample           (sample),
    .cmd              (cmd),
    .sts              (sts),
    .window_mean      (window_mean),
    .window_min       (window_min),
    .window_max       (window_max),
    .window_std       (window_std)
  );

endmodule

`default_nettype wire

[hdl/wsd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "window_statistics_decimator_defines.svh"

module wsd_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [31:0]            window_mean,
  input wire logic signed [SAMPLE_BITS-1:0] window_min,
  input wire logic signed [SAMPLE_BITS-1:0] window_max,
  input wire logic [31:0]                   window_std
);

  `WSD_ASSERT_NOW(a_min_le_max, clk, rst, out_valid, window_min <= window_max)
  `WSD_ASSERT_NOW(a_mean_in_range, clk, rst, out_valid, (window_mean >= window_min * 256) && (window_mean <= window_max * 256))
  `WSD_ASSERT_NOW(a_record_after_stall, clk, rst, $rose(out_valid), $past(in_stall))
  `WSD_ASSERT_NEXT(a_held_record, clk, rst, out_valid && out_stall, out_valid && $stable(window_std))

endmodule

bind window_statistics_decimator wsd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wsd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .window_mean (window_mean),
  .window_min  (window_min),
  .window_max  (window_max),
  .window_std  (window_std)
);

`default_nettype wire
